// ===== hw/rtl/npcs_pkg.sv =====
// Shared types and constants for the nearest palette colour search block.
// Holds request/result transaction structs, request codes and sequencer states.
// No dependencies.
package npcs_pkg;

    localparam int IDX_W  = 8;
    localparam int COMP_W = 8;
    localparam int DIST_W = 20;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RGB   = 2'd1,
        REQ_555   = 2'd2,
        REQ_INV   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INV,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_tag;

    typedef struct packed {
        t_req_type         req_type;
        logic [IDX_W-1:0]  entry_index;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [14:0]       color_555;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  closest_index;
        logic [DIST_W-1:0] best_distance;
    } t_res;

    localparam t_rgb WHITE = '{r: 8'hff, g: 8'hff, b: 8'hff};

    localparam logic [9:0] RED_BIAS  = 10'd512;
    localparam logic [9:0] BLUE_BIAS = 10'd767;

endpackage

// ===== hw/rtl/npcs_dist.sv =====
// Pipelined redmean distance unit, three register stages, one entry per cycle.
// Carries a tag (valid and palette index) alongside the data.
// Depends on npcs_pkg.
module npcs_dist
    import npcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tag              i_tag,
    input  t_rgb              i_entry,
    input  t_rgb              i_query,
    output t_tag              o_tag,
    output logic [DIST_W-1:0] o_dist,
    output logic              o_busy
);

    t_tag        r_tag1, r_tag2, r_tag3;
    logic [15:0] r_drsq, r_dgsq, r_dbsq;
    logic [7:0]  r_m;
    logic [17:0] r_wr, r_wg, r_wb;
    logic [DIST_W-1:0] r_dist;

    logic [7:0]  dr, dg, db;
    logic [8:0]  rsum;
    logic [25:0] pr, pb;

    always_comb begin
        dr   = (i_query.r > i_entry.r) ? i_query.r - i_entry.r : i_entry.r - i_query.r;
        dg   = (i_query.g > i_entry.g) ? i_query.g - i_entry.g : i_entry.g - i_query.g;
        db   = (i_query.b > i_entry.b) ? i_query.b - i_entry.b : i_entry.b - i_query.b;
        rsum = {1'b0, i_query.r} + {1'b0, i_entry.r};
        pr   = 26'(RED_BIAS + {2'b00, r_m}) * 26'(r_drsq);
        pb   = 26'(BLUE_BIAS - {2'b00, r_m}) * 26'(r_dbsq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
        end else begin
            r_tag1.valid <= i_tag.valid;
            r_tag2.valid <= r_tag1.valid;
            r_tag3.valid <= r_tag2.valid;
        end
        r_tag1.idx <= i_tag.idx;
        r_tag2.idx <= r_tag1.idx;
        r_tag3.idx <= r_tag2.idx;
    end

    always_ff @(posedge i_clk) begin
        r_drsq     <= dr * dr;
        r_dgsq     <= dg * dg;
        r_dbsq     <= db * db;
        r_m        <= rsum[8:1];
        r_wr       <= pr[25:8];
        r_wg       <= {r_dgsq, 2'b00};
        r_wb       <= pb[25:8];
        r_dist     <= DIST_W'(r_wr) + DIST_W'(r_wg) + DIST_W'(r_wb);
    end

    assign o_tag  = r_tag3;
    assign o_dist = r_dist;
    assign o_busy = r_tag1.valid | r_tag2.valid | r_tag3.valid;

endmodule

// ===== hw/rtl/nearest_palette_color_search.sv =====
// Nearest palette colour search: palette RAM, scan sequencer and best-match tracking.
// Write transaction: ready stays high after it is accepted; no result.
// RGB or 5-5-5 query: every palette entry is read through one RAM read port into one
// distance pipe, then the result is issued; an inverse query first reads its entry.
// A new request is accepted only once the previous query's result has been issued.
// Reset (synchronous, active low) clears control state; palette contents stay undefined.
module nearest_palette_color_search
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_res o_out_data
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    t_rgb r_mem [PALETTE_ENTRIES];
    t_rgb r_rd_data;
    t_tag r_rd_tag;

    t_state r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    t_rgb r_query, n_query;
    logic r_inv_oob, n_inv_oob;
    logic r_have, n_have;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [DIST_W-1:0] r_best_dist, n_best_dist;
    logic r_out_valid, n_out_valid;
    t_res r_out_data, n_out_data;

    logic [AW-1:0] rd_addr;
    logic issue, mem_we, accept, in_range;
    t_tag dist_tag;
    logic [DIST_W-1:0] dist_val;
    logic dist_busy;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign in_range    = ({1'b0, i_in_data.entry_index} < 9'(PALETTE_ENTRIES));
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_query     = r_query;
        n_inv_oob   = r_inv_oob;
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best_dist = r_best_dist;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        rd_addr     = r_cnt;
        issue       = 1'b0;
        mem_we      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cnt  = '0;
                    n_have = 1'b0;
                    unique case (i_in_data.req_type)
                        REQ_WRITE: begin
                            mem_we = in_range;
                        end
                        REQ_RGB: begin
                            n_query = '{r: i_in_data.red, g: i_in_data.green,
                                        b: i_in_data.blue};
                            n_state = ST_SCAN;
                        end
                        REQ_555: begin
                            n_query = '{r: {i_in_data.color_555[14:10], 3'b000},
                                        g: {i_in_data.color_555[9:5], 3'b000},
                                        b: {i_in_data.color_555[4:0], 3'b000}};
                            n_state = ST_SCAN;
                        end
                        REQ_INV: begin
                            rd_addr   = i_in_data.entry_index[AW-1:0];
                            n_inv_oob = !in_range;
                            n_state   = ST_INV;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INV: begin
                if (r_inv_oob || r_rd_data == WHITE) begin
                    n_query = WHITE;
                end else begin
                    n_query = ~r_rd_data;
                end
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                issue = 1'b1;
                if (r_cnt == AW'(PALETTE_ENTRIES - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_tag.valid && !dist_busy && (!r_out_valid || i_out_ready)) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{closest_index: r_best_idx, best_distance: r_best_dist};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (dist_tag.valid && (!r_have || dist_val < r_best_dist)) begin
            n_have      = 1'b1;
            n_best_idx  = dist_tag.idx;
            n_best_dist = dist_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
            r_rd_tag.valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_have      <= n_have;
            r_rd_tag.valid <= issue;
        end
        r_rd_tag.idx <= IDX_W'(r_cnt);
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_query      <= n_query;
        r_inv_oob    <= n_inv_oob;
        r_best_idx   <= n_best_idx;
        r_best_dist  <= n_best_dist;
        r_out_data   <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_in_data.entry_index[AW-1:0]] <= '{r: i_in_data.red, g: i_in_data.green,
                                                      b: i_in_data.blue};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    npcs_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_entry (r_rd_data),
        .i_query (r_query),
        .o_tag   (dist_tag),
        .o_dist  (dist_val),
        .o_busy  (dist_busy)
    );

endmodule

// ===== hw/rtl/npcs_checker.sv =====
// Port-level checks for the nearest palette colour search block, with bind.
// Observes the top level's ports only.
// Depends on npcs_pkg and nearest_palette_color_search.
module npcs_checker
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_req i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_res o_out_data
);

    logic query_acc, write_acc;

    assign query_acc = i_in_valid && o_in_ready && (i_in_data.req_type != REQ_WRITE);
    assign write_acc = i_in_valid && o_in_ready && (i_in_data.req_type == REQ_WRITE);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result transaction dropped or changed while stalled");

    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        write_acc |=> o_in_ready)
        else $error("not ready after a palette write");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_acc |-> ##PALETTE_ENTRIES !o_in_ready)
        else $error("ready again before the palette scan finished");

    a_result_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready && $past(!o_in_ready))
        else $error("result appeared outside the end of a query");

endmodule

bind nearest_palette_color_search npcs_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_npcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
